[src/ogu_pkg.sv]
package ogu_pkg;

  // Parameter defaults
  localparam int GRID_COLS_DEFAULT = 256;
  localparam int GRID_ROWS_DEFAULT = 256;
  localparam int NODE_BITS_DEFAULT = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_HIT_INCREMENT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MISS_INCREMENT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_LOW          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_HIGH         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OCCUPIED_THRESHOLD = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_ENABLE   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE        = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE        = 3'd7;

  // Register reset values
  localparam logic signed [15:0] HIT_INCREMENT_RST  = 16'sd3502;
  localparam logic signed [15:0] MISS_INCREMENT_RST = -16'sd1645;
  localparam logic signed [15:0] CLAMP_LOW_RST      = -16'sd8192;
  localparam logic signed [15:0] CLAMP_HIGH_RST     = 16'sd14336;
  localparam logic signed [15:0] OCC_THRESHOLD_RST  = 16'sd0;
  localparam logic [8:0]         DIM_IN_USE_RST     = 9'd256;

  // Operation codes
  localparam logic [2:0] OP_FREE  = 3'd0;
  localparam logic [2:0] OP_HIT   = 3'd1;
  localparam logic [2:0] OP_FOOT  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_SWEEP = 3'd4;
  localparam logic [2:0] OP_LOAD  = 3'd5;

  // Cell state values as reported
  localparam logic signed [7:0] VAL_UNKNOWN = -8'sd1;
  localparam logic signed [7:0] VAL_FREE    = 8'sd0;
  localparam logic signed [7:0] VAL_OCC     = 8'sd100;
  localparam logic signed [7:0] VAL_FOOT    = -8'sd2;

  // Cell state as stored
  typedef enum logic [1:0] {
    CODE_UNKNOWN,
    CODE_FREE,
    CODE_OCC,
    CODE_FOOT
  } ogu_code_t;

  typedef struct packed {
    logic        [2:0]  op;
    logic        [7:0]  cell_x;
    logic        [7:0]  cell_y;
    logic signed [15:0] node_id;
    logic signed [7:0]  load_value;
  } ogu_in_t;

  typedef struct packed {
    logic signed [7:0]  cell_state;
    logic signed [15:0] cell_log_odds;
    logic signed [15:0] cell_owner;
    logic               write_blocked;
    logic signed [7:0]  map_value;
  } ogu_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_input;
    logic sweep_issue;
    logic clear_issue;
    logic commit;
  } ogu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_go;
    logic sweep_last;
    logic clear_last;
    logic out_room;
  } ogu_status_t;

  function automatic logic signed [7:0] code_value(ogu_code_t c);
    logic signed [7:0] v;
    case (c)
      CODE_FREE: v = VAL_FREE;
      CODE_OCC:  v = VAL_OCC;
      CODE_FOOT: v = VAL_FOOT;
      default:   v = VAL_UNKNOWN;
    endcase
    return v;
  endfunction

endpackage

[src/occupancy_grid_cell_updater.sv]
// Occupancy grid cell updater.
// Input channel in_valid/in_stall/in_data carries one cell operation per item
// (free, hit, footprint, read, end-of-batch sweep, load); the output channel
// out_valid/out_stall/out_data returns exactly one result item per input item.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// Each item is a read-modify-write of the cell memory, and no new item is
// taken before its write-back: the read is issued at accept, the write and
// result register load follow in the execute state once the output register
// has room. A sweep item, when both used dimensions are at least 3, walks the
// interior of the used grid one cell per cycle through the same memory, then
// passes the drain and lookup states and reads the addressed cell again.
// After reset the cell memory is cleared one cell per cycle; in_stall stays
// high until every cell is cleared, while configuration writes are still taken.
// Reset also restores register defaults and empties the output register.
// When the receiver stalls, the result is held in the output register; one
// further item may be accepted, and it waits before its write-back until the
// output register is free.
module occupancy_grid_cell_updater #(
  parameter int GRID_COLS = ogu_pkg::GRID_COLS_DEFAULT,
  parameter int GRID_ROWS = ogu_pkg::GRID_ROWS_DEFAULT,
  parameter int NODE_BITS = ogu_pkg::NODE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ogu_pkg::ogu_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ogu_pkg::ogu_out_t               out_data,
  input  logic                            cfg_write,
  input  logic [ogu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ogu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ogu_pkg::*;

  ogu_cmd_t    cmd;
  ogu_status_t status;

  ogu_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  ogu_datapath #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS),
    .NODE_BITS(NODE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cmd      (cmd),
    .status   (status)
  );

`ifndef ASSERT_OFF
  // One item in flight: an accept is never followed directly by another
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted in the cycle after an accept");

  // A result is only written while the output register can take it
  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_room)
    else $error("result committed over a held output");

  // Clearing pass excludes item work
  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_issue |-> (!cmd.commit && !cmd.sweep_issue && in_stall))
    else $error("item work during the clearing pass");

  // Every commit shows a result on the next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");
`endif

endmodule

[src/ogu_ram.sv]
module ogu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/ogu_datapath.sv]
module ogu_datapath #(
  parameter int GRID_COLS = ogu_pkg::GRID_COLS_DEFAULT,
  parameter int GRID_ROWS = ogu_pkg::GRID_ROWS_DEFAULT,
  parameter int NODE_BITS = ogu_pkg::NODE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ogu_pkg::ogu_in_t                   in_data,
  input  logic                               cfg_write,
  input  logic [ogu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ogu_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ogu_pkg::ogu_out_t                  out_data,
  input  ogu_pkg::ogu_cmd_t                  cmd,
  output ogu_pkg::ogu_status_t               status
);

  import ogu_pkg::*;

  localparam int CELLS   = GRID_COLS * GRID_ROWS;
  localparam int AW      = $clog2(CELLS);
  localparam int DIM_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
  localparam int LIM_W   = $clog2(DIM_MAX + 512);
  localparam int WW      = 2 + 16 + NODE_BITS;

  // Configuration registers
  logic signed [15:0] hit_inc, miss_inc, clamp_lo, clamp_hi, occ_thr;
  logic               thr_en;
  logic [8:0]         cols_use, rows_use;

  // Captured item
  logic [2:0]                  op_q;
  logic signed [NODE_BITS-1:0] k_q;
  logic signed [7:0]           lv_q;
  logic                        item_in_range;
  logic [AW-1:0]               item_addr;

  // Sweep walk
  logic [LIM_W-1:0] sx, sy, cols_lim, rows_lim;
  logic             sweep_ok;
  logic [AW-1:0]    sweep_addr;
  logic             pipe_valid;
  logic [AW-1:0]    pipe_addr;

  // Clearing pass
  logic [AW-1:0] clr_cnt;

  // Memory ports
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr, in_addr;
  logic [WW-1:0] wr_data, rd_data;
  logic          in_in_range;

  // Cell fields as read
  ogu_code_t                   rd_code;
  logic signed [15:0]          rd_lo;
  logic signed [NODE_BITS-1:0] rd_ow;

  // Update
  logic                        k_pos, newer, blocked, write_op;
  logic signed [15:0]          inc;
  logic signed [16:0]          sum, sum_lo;
  logic signed [15:0]          lo_added;
  ogu_code_t                   new_code;
  logic signed [15:0]          new_lo;
  logic signed [NODE_BITS-1:0] new_ow;
  ogu_out_t                    result;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_inc  <= HIT_INCREMENT_RST;
      miss_inc <= MISS_INCREMENT_RST;
      clamp_lo <= CLAMP_LOW_RST;
      clamp_hi <= CLAMP_HIGH_RST;
      occ_thr  <= OCC_THRESHOLD_RST;
      thr_en   <= 1'b0;
      cols_use <= DIM_IN_USE_RST;
      rows_use <= DIM_IN_USE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HIT_INCREMENT:      hit_inc  <= cfg_data;
        REG_MISS_INCREMENT:     miss_inc <= cfg_data;
        REG_CLAMP_LOW:          clamp_lo <= cfg_data;
        REG_CLAMP_HIGH:         clamp_hi <= cfg_data;
        REG_OCCUPIED_THRESHOLD: occ_thr  <= cfg_data;
        REG_THRESHOLD_ENABLE:   thr_en   <= cfg_data[0];
        REG_COLS_IN_USE:        cols_use <= cfg_data[8:0];
        REG_ROWS_IN_USE:        rows_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Address of the incoming cell
  assign in_addr = AW'(32'(in_data.cell_y) * GRID_COLS + 32'(in_data.cell_x));
  assign in_in_range = (32'(in_data.cell_x) < 32'(GRID_COLS)) &&
                       (32'(in_data.cell_y) < 32'(GRID_ROWS));

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q          <= in_data.op;
      k_q           <= NODE_BITS'(in_data.node_id);
      lv_q          <= in_data.load_value;
      item_in_range <= in_in_range;
      item_addr     <= in_addr;
    end
  end

  // Sweep bounds: interior of the used part of the grid
  assign cols_lim = (LIM_W'(cols_use) < LIM_W'(GRID_COLS)) ? LIM_W'(cols_use)
                                                           : LIM_W'(GRID_COLS);
  assign rows_lim = (LIM_W'(rows_use) < LIM_W'(GRID_ROWS)) ? LIM_W'(rows_use)
                                                           : LIM_W'(GRID_ROWS);
  assign sweep_ok   = (cols_lim >= LIM_W'(3)) && (rows_lim >= LIM_W'(3));
  assign sweep_addr = AW'(32'(sy) * GRID_COLS + 32'(sx));

  // Sweep counters and write-back stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= cmd.sweep_issue;
    end
    pipe_addr <= sweep_addr;
    if (cmd.capture) begin
      sx <= LIM_W'(1);
      sy <= LIM_W'(1);
    end else if (cmd.sweep_issue) begin
      if (sx == cols_lim - LIM_W'(2)) begin
        sx <= LIM_W'(1);
        sy <= sy + LIM_W'(1);
      end else begin
        sx <= sx + LIM_W'(1);
      end
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_issue) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Read address select
  always_comb begin
    if (cmd.sweep_issue) begin
      rd_addr = sweep_addr;
    end else if (cmd.rd_input) begin
      rd_addr = in_addr;
    end else begin
      rd_addr = item_addr;
    end
  end

  ogu_ram #(
    .WIDTH(WW),
    .DEPTH(CELLS)
  ) u_cells (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_code = ogu_code_t'(rd_data[WW-1 -: 2]);
  assign rd_lo   = rd_data[NODE_BITS +: 16];
  assign rd_ow   = rd_data[NODE_BITS-1:0];

  // Saturating log-odds add, low clamp first then high
  assign inc    = (op_q == OP_HIT) ? hit_inc : miss_inc;
  assign sum    = 17'(rd_lo) + 17'(inc);
  assign sum_lo = (sum < 17'(clamp_lo)) ? 17'(clamp_lo) : sum;
  assign lo_added = (sum_lo > 17'(clamp_hi)) ? clamp_hi : sum_lo[15:0];

  // Cell update and result
  always_comb begin
    k_pos    = k_q > 0;
    newer    = (rd_code != CODE_UNKNOWN) && k_pos &&
               ((k_q < rd_ow) || (rd_ow < 0));
    new_code = rd_code;
    new_lo   = rd_lo;
    new_ow   = rd_ow;
    blocked  = 1'b0;
    write_op = 1'b0;
    result   = '0;
    case (op_q)
      OP_FREE: begin
        write_op = 1'b1;
        if (rd_code == CODE_FOOT || newer) begin
          blocked = 1'b1;
        end else begin
          if (k_pos) new_ow = k_q;
          new_code = CODE_FREE;
          if (rd_ow != k_q) new_lo = lo_added;
        end
      end
      OP_HIT: begin
        write_op = 1'b1;
        if (rd_code == CODE_FOOT || newer) begin
          blocked = 1'b1;
        end else begin
          if (k_pos) new_ow = k_q;
          if (rd_ow != k_q || rd_code != CODE_OCC) new_lo = lo_added;
          new_code = CODE_OCC;
        end
      end
      OP_FOOT: begin
        write_op = 1'b1;
        if (newer) begin
          blocked = 1'b1;
        end else begin
          if (k_pos) begin
            new_ow = k_q;
            new_lo = clamp_lo;
          end
          new_code = CODE_FOOT;
        end
      end
      OP_READ: begin
        if (thr_en) begin
          if (rd_lo == 16'sd0) result.map_value = VAL_UNKNOWN;
          else if (rd_lo >= occ_thr) result.map_value = VAL_OCC;
          else result.map_value = VAL_FREE;
        end else begin
          result.map_value = (rd_code == CODE_FOOT) ? VAL_FREE : code_value(rd_code);
        end
      end
      OP_LOAD: begin
        write_op = 1'b1;
        if (lv_q == VAL_FREE) begin
          new_code = CODE_FREE;
          new_lo   = clamp_lo;
        end else if (lv_q == VAL_OCC) begin
          new_code = CODE_OCC;
          new_lo   = clamp_hi;
        end else begin
          new_code = CODE_UNKNOWN;
          new_lo   = 16'sd0;
        end
        new_ow = '0;
      end
      default: ;
    endcase
    if (item_in_range) begin
      result.cell_state    = code_value(new_code);
      result.cell_log_odds = new_lo;
      result.cell_owner    = 16'(new_ow);
      result.write_blocked = blocked;
    end else begin
      // Outside the grid: fixed report, no cell touched
      result.cell_state    = VAL_UNKNOWN;
      result.cell_log_odds = 16'sd0;
      result.cell_owner    = 16'sd0;
      result.write_blocked = write_op;
      result.map_value     = (op_q == OP_READ) ? VAL_UNKNOWN : VAL_FREE;
    end
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item_addr;
    wr_data = {new_code, new_lo, new_ow};
    if (cmd.clear_issue) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = {CODE_UNKNOWN, 16'd0, NODE_BITS'(0)};
    end else if (pipe_valid) begin
      wr_en   = (rd_code == CODE_FOOT);
      wr_addr = pipe_addr;
      wr_data = {CODE_FREE, rd_data[WW-3:0]};
    end else if (cmd.commit) begin
      wr_en = item_in_range && write_op && !blocked;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.commit) begin
      out_data <= result;
    end
  end

  // Status
  assign status.sweep_go   = (in_data.op == OP_SWEEP) && sweep_ok;
  assign status.sweep_last = (sx == cols_lim - LIM_W'(2)) && (sy == rows_lim - LIM_W'(2));
  assign status.clear_last = (clr_cnt == AW'(CELLS - 1));
  assign status.out_room   = !out_valid || !out_stall;

endmodule

[src/ogu_controller.sv]
module ogu_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ogu_pkg::ogu_status_t status,
  output ogu_pkg::ogu_cmd_t    cmd
);

  import ogu_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_LOOKUP,
    S_EXEC
  } state_t;

  state_t state;

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (status.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= status.sweep_go ? S_SWEEP : S_EXEC;
        end
        S_SWEEP: begin
          if (status.sweep_last) state <= S_DRAIN;
        end
        S_DRAIN:  state <= S_LOOKUP;
        S_LOOKUP: state <= S_EXEC;
        S_EXEC: begin
          if (status.out_room) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Commands
  assign in_stall        = (state != S_IDLE);
  assign cmd.capture     = (state == S_IDLE) && in_valid;
  assign cmd.rd_input    = (state == S_IDLE);
  assign cmd.sweep_issue = (state == S_SWEEP);
  assign cmd.clear_issue = (state == S_CLEAR);
  assign cmd.commit      = (state == S_EXEC) && status.out_room;

endmodule

[test/tb_occupancy_grid_cell_updater.sv]
`timescale 1ns / 1ps

module tb_occupancy_grid_cell_updater;
  import ogu_pkg::*;

  localparam int CLK_HALF_NS   = 6;
  localparam int GRID_COLS     = GRID_COLS_DEFAULT;
  localparam int GRID_ROWS     = GRID_ROWS_DEFAULT;
  localparam int CELL_COUNT    = GRID_COLS * GRID_ROWS;
  localparam int ADDR_SPAN     = 20;
  localparam int SETTLE_CYCLES = 6;
  localparam int NUM_PHASES    = 5;
  localparam int LIMIT_CYCLES  = 1_000_000;

  // op codes the block leaves unused
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic signed [15:0] hit;
    logic signed [15:0] miss;
    logic signed [15:0] clamp_lo;
    logic signed [15:0] clamp_hi;
    logic signed [15:0] thr;
    logic               thr_en;
    logic        [8:0]  cols;
    logic        [8:0]  rows;
  } grid_cfg_t;

  typedef struct packed {
    grid_cfg_t cfg;
    int        items;
    int        idle_pct;
    int        stall_pct;
  } phase_t;

  typedef struct packed {
    ogu_in_t  item;
    logic     known;
    ogu_out_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  ogu_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ogu_out_t out_data;
  logic     cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // shadow of the grid and the registers
  logic signed [7:0]  state_mem [CELL_COUNT];
  logic signed [15:0] odds_mem  [CELL_COUNT];
  logic signed [15:0] owner_mem [CELL_COUNT];
  grid_cfg_t          active_cfg;

  ogu_out_t expected_cells [$];
  dir_row_t dir_rows [$];
  phase_t   phases [NUM_PHASES];
  int       mismatch_count = 0;
  int       idle_pct = 20;
  int       stall_pct = 20;
  int       stall_left = 0;

  occupancy_grid_cell_updater u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // saturating log-odds add, low clamp first so inverted clamps end high
  function automatic logic signed [15:0] clamp_sum(input logic signed [15:0] cur,
                                                    input logic signed [15:0] inc);
    int s;
    s = int'(cur) + int'(inc);
    if (s < int'(active_cfg.clamp_lo)) s = int'(active_cfg.clamp_lo);
    if (s > int'(active_cfg.clamp_hi)) s = int'(active_cfg.clamp_hi);
    return s[15:0];
  endfunction

  // applies one item to the shadow grid and returns the result it should give
  function automatic ogu_out_t predict_cell_op(input ogu_in_t item);
    ogu_out_t          res;
    int                a, k, n, ncols, nrows;
    logic signed [7:0] v;
    logic              newer;
    res = '0;
    // sweep runs before the addressed cell is reported
    if (item.op == OP_SWEEP) begin
      ncols = (active_cfg.cols < GRID_COLS) ? int'(active_cfg.cols) : GRID_COLS;
      nrows = (active_cfg.rows < GRID_ROWS) ? int'(active_cfg.rows) : GRID_ROWS;
      if (ncols >= 3 && nrows >= 3) begin
        for (int sy = 1; sy < nrows - 1; sy++) begin
          for (int sx = 1; sx < ncols - 1; sx++) begin
            if (state_mem[sy * GRID_COLS + sx] == VAL_FOOT)
              state_mem[sy * GRID_COLS + sx] = VAL_FREE;
          end
        end
      end
    end
    a = int'(item.cell_y) * GRID_COLS + int'(item.cell_x);
    v = state_mem[a];
    n = owner_mem[a];
    k = item.node_id;
    // a newer owner blocks writes from an older positive node
    newer = (v != VAL_UNKNOWN) && (k > 0) && (k < n || n < 0);
    case (item.op)
      OP_FREE: begin
        if (v == VAL_FOOT || newer) begin
          res.write_blocked = 1'b1;
        end else begin
          if (k > 0) owner_mem[a] = k[15:0];
          state_mem[a] = VAL_FREE;
          if (n != k) odds_mem[a] = clamp_sum(odds_mem[a], active_cfg.miss);
        end
      end
      OP_HIT: begin
        if (v == VAL_FOOT || newer) begin
          res.write_blocked = 1'b1;
        end else begin
          if (k > 0) owner_mem[a] = k[15:0];
          if (n != k || v != VAL_OCC) odds_mem[a] = clamp_sum(odds_mem[a], active_cfg.hit);
          state_mem[a] = VAL_OCC;
        end
      end
      OP_FOOT: begin
        if (newer) begin
          res.write_blocked = 1'b1;
        end else begin
          if (k > 0) begin
            owner_mem[a] = k[15:0];
            odds_mem[a]  = active_cfg.clamp_lo;
          end
          state_mem[a] = VAL_FOOT;
        end
      end
      OP_READ: begin
        if (active_cfg.thr_en) begin
          if (odds_mem[a] == 16'sd0) res.map_value = VAL_UNKNOWN;
          else if (odds_mem[a] >= active_cfg.thr) res.map_value = VAL_OCC;
          else res.map_value = VAL_FREE;
        end else begin
          res.map_value = (v == VAL_FOOT) ? VAL_FREE : v;
        end
      end
      OP_LOAD: begin
        if (item.load_value == VAL_FREE) begin
          state_mem[a] = VAL_FREE;
          odds_mem[a]  = active_cfg.clamp_lo;
        end else if (item.load_value == VAL_OCC) begin
          state_mem[a] = VAL_OCC;
          odds_mem[a]  = active_cfg.clamp_hi;
        end else begin
          state_mem[a] = VAL_UNKNOWN;
          odds_mem[a]  = '0;
        end
        owner_mem[a] = '0;
      end
      default: ;
    endcase
    res.cell_state    = state_mem[a];
    res.cell_log_odds = odds_mem[a];
    res.cell_owner    = owner_mem[a];
    return res;
  endfunction

  // mostly a small patch of cells with a few owners, so ownership and sweep interact
  function automatic ogu_in_t random_cell_op();
    ogu_in_t item;
    int      r;
    r = $urandom_range(99);
    if (r < 24) item.op = OP_FREE;
    else if (r < 48) item.op = OP_HIT;
    else if (r < 62) item.op = OP_FOOT;
    else if (r < 80) item.op = OP_READ;
    else if (r < 85) item.op = OP_SWEEP;
    else if (r < 95) item.op = OP_LOAD;
    else item.op = $urandom_range(1) ? OP_SPARE7 : OP_SPARE6;
    if ($urandom_range(99) < 85) begin
      item.cell_x = 8'($urandom_range(ADDR_SPAN - 1));
      item.cell_y = 8'($urandom_range(ADDR_SPAN - 1));
    end else begin
      item.cell_x = 8'($urandom_range(255));
      item.cell_y = 8'($urandom_range(255));
    end
    r = $urandom_range(99);
    if (r < 55) item.node_id = 16'($urandom_range(1, 8));
    else if (r < 70) item.node_id = 16'(-int'($urandom_range(1, 8)));
    else if (r < 78) item.node_id = '0;
    else item.node_id = 16'($urandom());
    case ($urandom_range(3))
      0: item.load_value = VAL_FREE;
      1: item.load_value = VAL_OCC;
      2: item.load_value = VAL_UNKNOWN;
      default: item.load_value = 8'($urandom());
    endcase
    return item;
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic add_row(input logic [2:0] op, input int x, input int y,
                         input int node, input int lv);
    dir_row_t row;
    row.item = '{op, x[7:0], y[7:0], node[15:0], lv[7:0]};
    row.known = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_known_row(input logic [2:0] op, input int x, input int y,
                               input int node, input int lv, input int st,
                               input int odds, input int owner, input int mv);
    dir_row_t row;
    row.item = '{op, x[7:0], y[7:0], node[15:0], lv[7:0]};
    row.known = 1'b1;
    row.want = '{st[7:0], odds[15:0], owner[15:0], 1'b0, mv[7:0]};
    dir_rows.push_back(row);
  endtask

  // random sender gap before the next item
  task automatic sender_gap();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_cell_op(input ogu_in_t item, input logic known, input ogu_out_t want);
    ogu_out_t pred;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_cell_op(item);
    expected_cells.push_back(known ? want : pred);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_grid(input grid_cfg_t c);
    logic [CFG_DATA_W-1:0] word [8];
    word[REG_HIT_INCREMENT]      = c.hit;
    word[REG_MISS_INCREMENT]     = c.miss;
    word[REG_CLAMP_LOW]          = c.clamp_lo;
    word[REG_CLAMP_HIGH]         = c.clamp_hi;
    word[REG_OCCUPIED_THRESHOLD] = c.thr;
    word[REG_THRESHOLD_ENABLE]   = {15'd0, c.thr_en};
    word[REG_COLS_IN_USE]        = {7'd0, c.cols};
    word[REG_ROWS_IN_USE]        = {7'd0, c.rows};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= word[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    active_cfg = c;
  endtask

  // receiver stalls in bursts, each started with a stall_pct percent chance
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    ogu_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, out_data);
        mismatch_count++;
      end else begin
        want = expected_cells.pop_front();
        check_field("cell_state", want.cell_state, out_data.cell_state);
        check_field("cell_log_odds", want.cell_log_odds, out_data.cell_log_odds);
        check_field("cell_owner", want.cell_owner, out_data.cell_owner);
        check_field("write_blocked", want.write_blocked, out_data.write_blocked);
        check_field("map_value", want.map_value, out_data.map_value);
      end
    end
  end

  // timeout: clearing pass plus two full sweeps is well under this
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      state_mem[i] = VAL_UNKNOWN;
      odds_mem[i]  = '0;
      owner_mem[i] = '0;
    end
    active_cfg = '{HIT_INCREMENT_RST, MISS_INCREMENT_RST, CLAMP_LOW_RST, CLAMP_HIGH_RST,
                   OCC_THRESHOLD_RST, 1'b0, DIM_IN_USE_RST, DIM_IN_USE_RST};

    // directed: reset contents, load extremes, ownership, footprint, full sweep
    add_known_row(OP_READ, 10, 10, 0, 0, VAL_UNKNOWN, 0, 0, VAL_UNKNOWN);
    add_known_row(OP_LOAD, 255, 255, 0, VAL_OCC, VAL_OCC, CLAMP_HIGH_RST, 0, 0);
    add_known_row(OP_LOAD, 0, 0, 0, VAL_FREE, VAL_FREE, CLAMP_LOW_RST, 0, 0);
    add_known_row(OP_LOAD, 0, 255, 0, VAL_UNKNOWN, VAL_UNKNOWN, 0, 0, 0);
    add_known_row(OP_LOAD, 255, 0, 0, -128, VAL_UNKNOWN, 0, 0, 0);
    add_known_row(OP_LOAD, 7, 7, 0, 127, VAL_UNKNOWN, 0, 0, 0);
    add_row(OP_FREE, 5, 5, 3, 0);
    add_row(OP_FREE, 5, 5, 3, 0);        // same owner: odds unchanged
    add_row(OP_HIT, 5, 5, 3, 0);
    add_row(OP_HIT, 5, 5, 3, 0);         // already occupied by same owner
    add_row(OP_FREE, 5, 5, 7, 0);        // later node takes over
    add_row(OP_HIT, 5, 5, 2, 0);         // older node blocked
    add_row(OP_FREE, 5, 5, -5, 0);       // temporary node keeps owner
    add_row(OP_FOOT, 6, 6, 4, 0);
    add_row(OP_FREE, 6, 6, 4, 0);        // blocked on footprint
    add_row(OP_HIT, 6, 6, 9, 0);         // blocked on footprint
    add_row(OP_FOOT, 6, 6, -32768, 0);
    add_row(OP_FOOT, 0, 6, 32767, 0);    // border cell, survives the sweep
    add_row(OP_READ, 6, 6, 0, 0);
    add_row(OP_READ, 5, 5, 0, 0);
    add_row(OP_SPARE6, 5, 5, 1, 0);
    add_row(OP_SPARE7, 255, 255, -1, -1);
    add_row(OP_SWEEP, 6, 6, 0, 0);
    add_row(OP_READ, 6, 6, 0, 0);
    add_row(OP_READ, 0, 6, 0, 0);

    phases[0] = '{'{HIT_INCREMENT_RST, MISS_INCREMENT_RST, CLAMP_LOW_RST, CLAMP_HIGH_RST,
                    OCC_THRESHOLD_RST, 1'b1, 9'd16, 9'd16}, 130, 25, 25};
    phases[1] = '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                    -16'sd32768, 1'b1, 9'd1, 9'd2}, 130, 0, 40};
    phases[2] = '{'{16'sd100, -16'sd100, 16'sd1000, -16'sd1000,
                    16'sd1, 1'b0, 9'd3, 9'd3}, 130, 40, 0};
    phases[3] = '{'{-16'sd32768, 16'sd32767, -16'sd4096, 16'sd4096,
                    16'sd32767, 1'b1, 9'd12, 9'd227}, 130, 20, 20};
    phases[4] = '{'{16'sd2048, -16'sd2048, -16'sd32768, 16'sd32767,
                    -16'sd1, 1'b0, 9'd256, 9'd18}, 130, 15, 15};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      sender_gap();
      send_cell_op(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      hold_until_drained();
      program_grid(phases[p].cfg);
      idle_pct  = phases[p].idle_pct;
      stall_pct = phases[p].stall_pct;
      for (int n = 0; n < phases[p].items; n++) begin
        // let everything drain once with the sender held back
        if (p == 3 && n == 65) hold_until_drained();
        // closing stretch runs flat out
        if (p == NUM_PHASES - 1 && n == 50) begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        sender_gap();
        send_cell_op(random_cell_op(), 1'b0, '0);
      end
    end

    hold_until_drained();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[occupancy_grid_cell_updater.f]
src/ogu_pkg.sv
src/ogu_ram.sv
src/ogu_datapath.sv
src/ogu_controller.sv
src/occupancy_grid_cell_updater.sv
test/tb_occupancy_grid_cell_updater.sv
